// ===== sv/signed_int_to_decimal_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text block
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge. The assertion is disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SITDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/sitda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and types for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
  localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int IDX_W      = $clog2(DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_NL    = 8'd10;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_DIGIT,
    SEL_NL
  } sel_e;

  typedef struct packed {
    logic             load;
    logic             shift;
    sel_e             sel;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic dig_zero;
  } sts_t;

endpackage

// ===== sv/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed integer per request into its decimal text: optional
// '-', the digits most significant first, then a newline flagged as last.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i / in_stall_o   value_i
// out       output     out_valid_o / out_stall_i char_code_o, last_o
//
// A request passes through an accept step, VALUE_BITS (32) steps of the
// shift-and-add-3 converter (one bit per cycle), a step per skipped leading zero
// plus one to find the first digit, and one step per character.
// The next request is taken once the newline has been accepted.
// Reset (asynchronous, active low) returns the sequencer to idle.
// Output stall holds the current character and adds its cycles; nothing drops.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [sitda_pkg::VALUE_BITS-1:0] value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [7:0]                              char_code_o,
  output logic                                    last_o
);

  // Commands from the sequencer and status back from the datapath.
  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath holds the magnitude and BCD digits; the characters are picked
  // from registered digits, so they hold steady while the output stalls.
  sitda_dp u_dp (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

// ===== sv/sitda_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: takes a request, runs the binary to BCD shifts, skips leading
// zeros, then walks the sign, digits and newline out.
// ----------------------------------------------------------------------------
module sitda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sitda_pkg::sts_t  sts_i,
  output sitda_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;
  localparam logic [2:0] ST_NL    = 3'd5;

  localparam logic [sitda_pkg::CNT_W-1:0] CNT_LAST =
    sitda_pkg::CNT_W'(sitda_pkg::VALUE_BITS - 1);
  localparam logic [sitda_pkg::IDX_W-1:0] IDX_TOP =
    sitda_pkg::IDX_W'(sitda_pkg::DIGITS - 1);

  logic [2:0]                  state_q, state_d;
  logic [sitda_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [sitda_pkg::IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cmd_o.load  = 1'b0;
    cmd_o.shift = 1'b0;
    cmd_o.sel   = sitda_pkg::SEL_DIGIT;
    cmd_o.idx   = idx_q;
    out_valid_o = 1'b0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (cnt_q == CNT_LAST) begin
          idx_d   = IDX_TOP;
          state_d = sts_i.neg ? ST_SIGN : ST_SKIP;
        end else begin
          cnt_d = cnt_q + sitda_pkg::CNT_W'(1);
        end
      end
      ST_SIGN: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = sitda_pkg::SEL_MINUS;
        if (!out_stall_i) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.dig_zero && (idx_q != '0)) begin
          idx_d = idx_q - sitda_pkg::IDX_W'(1);
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (idx_q == '0) begin
            state_d = ST_NL;
          end else begin
            idx_d = idx_q - sitda_pkg::IDX_W'(1);
          end
        end
      end
      ST_NL: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = sitda_pkg::SEL_NL;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== sv/sitda_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude and sign registers, shift-and-add-3 BCD converter and
// the character select.
// ----------------------------------------------------------------------------
module sitda_dp (
  input  logic                               clk_i,
  input  logic signed [sitda_pkg::VALUE_BITS-1:0] value_i,
  input  sitda_pkg::cmd_t                    cmd_i,
  output sitda_pkg::sts_t                    sts_o,
  output logic [7:0]                         char_code_o,
  output logic                               last_o
);

  localparam int VB = sitda_pkg::VALUE_BITS;
  localparam int BW = sitda_pkg::BCD_W;

  logic [VB-1:0] mag_q, mag_d;
  logic [BW-1:0] bcd_q, bcd_d;
  logic          neg_q, neg_d;
  logic [BW-1:0] adj;
  logic [3:0]    cur_dig;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
      adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? (bcd_q[d*4 +: 4] + 4'd3)
                                                 : bcd_q[d*4 +: 4];
    end
  end

  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      neg_d = value_i[VB-1];
      mag_d = value_i[VB-1] ? (~value_i + VB'(1)) : value_i;
      bcd_d = '0;
    end else if (cmd_i.shift) begin
      bcd_d = {adj[BW-2:0], mag_q[VB-1]};
      mag_d = {mag_q[VB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign cur_dig        = bcd_q[{cmd_i.idx, 2'b00} +: 4];
  assign sts_o.neg      = neg_q;
  assign sts_o.dig_zero = (cur_dig == 4'd0);

  always_comb begin
    case (cmd_i.sel)
      sitda_pkg::SEL_MINUS: char_code_o = sitda_pkg::CHAR_MINUS;
      sitda_pkg::SEL_DIGIT: char_code_o = sitda_pkg::CHAR_ZERO + {4'd0, cur_dig};
      sitda_pkg::SEL_NL:    char_code_o = sitda_pkg::CHAR_NL;
      default:              char_code_o = sitda_pkg::CHAR_NL;
    endcase
  end

  assign last_o = (cmd_i.sel == sitda_pkg::SEL_NL);

endmodule

// ===== sv/sitda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module sitda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_code_o,
  input logic       last_o
);

  logic       in_acc;
  logic       out_wait;
  logic       is_nl;
  logic [8:0] out_word;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_wait = out_valid_o && out_stall_i;
  assign is_nl    = (char_code_o == sitda_pkg::CHAR_NL);
  assign out_word = {char_code_o, last_o};

  // No request is taken while characters of an earlier one are pending.
  `SITDA_ASSERT_SAME(a_idle_on_accept, clk_i, rst_ni, in_acc, !out_valid_o)
  // Busy right after taking a request.
  `SITDA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  // A stalled character holds.
  `SITDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_word))
  // Last marks the newline and nothing else.
  `SITDA_ASSERT_SAME(a_last_is_nl, clk_i, rst_ni, out_valid_o && last_o, is_nl)
  `SITDA_ASSERT_SAME(a_nl_is_last, clk_i, rst_ni, out_valid_o && !last_o, !is_nl)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .char_code_o (char_code_o),
  .last_o      (last_o)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for signed_int_to_decimal_ascii
// Sends signed integers into the converter and checks each character of the
// decimal text it returns against a local predictor. A directed table covers
// zero, the extremes and the digit-count boundaries. Random requests follow,
// with random gaps and stalls on both sides, a long output hold-off and a
// pause that lets the block drain.
// ----------------------------------------------------------------------------
module testbench;

  // One character of decimal text as the block should send it.
  typedef struct {
    logic [7:0] code;
    logic       fin;
  } text_char_t;

  // One row of the directed table. An empty text means the predictor decides.
  typedef struct {
    logic signed [sitda_pkg::VALUE_BITS-1:0] value;
    string                                   text;
  } table_row_t;

  localparam int RANDOM_REQUESTS = 330;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 80;
  localparam int REPORT_LIMIT    = 10;

  logic                                    clk_i;
  logic                                    rst_ni;
  logic                                    in_valid_i;
  logic                                    in_stall_o;
  logic signed [sitda_pkg::VALUE_BITS-1:0] value_i;
  logic                                    out_valid_o;
  logic                                    out_stall_i;
  logic [7:0]                              char_code_o;
  logic                                    last_o;

  // Characters still owed by the block, oldest first.
  text_char_t pending_text[$];
  table_row_t directed_rows[$];

  int mismatch_count = 0;
  // Set by the stimulus process: how long the receiver must hold off.
  int hold_off_left  = 0;
  // High during the stretch in which neither side idles.
  logic steady       = 1'b0;

  text_char_t seen_char;
  text_char_t want_char;

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // 4 ns clock.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Count a failure and print the first few of them.
  task automatic note_mismatch(string what, text_char_t want, text_char_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected char %0d last %0b, got char %0d last %0b",
               $time, what, want.code, want.fin, got.code, got.fin);
    end
  endtask

  // Append the text the block must produce for one integer: an optional
  // minus sign, the digits most significant first, then the closing newline.
  function automatic void predict_text(logic signed [sitda_pkg::VALUE_BITS-1:0] v);
    logic [sitda_pkg::VALUE_BITS-1:0] magnitude;
    logic [7:0]                       digits[$];
    logic                             negative;
    negative  = v[sitda_pkg::VALUE_BITS-1];
    magnitude = v;
    // Work on the unsigned magnitude so the most negative value survives.
    if (negative) begin
      magnitude = ~magnitude + 1'b1;
    end
    do begin
      digits.push_front(sitda_pkg::CHAR_ZERO + 8'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      pending_text.push_back('{sitda_pkg::CHAR_MINUS, 1'b0});
    end
    foreach (digits[i]) begin
      pending_text.push_back('{digits[i], 1'b0});
    end
    pending_text.push_back('{sitda_pkg::CHAR_NL, 1'b1});
  endfunction

  // Queue a typed-in text; only its final character carries last.
  function automatic void expect_literal(string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_text.push_back('{8'(text[i]), 1'(i == text.len() - 1)});
    end
  endfunction

  function automatic void add_row(logic signed [sitda_pkg::VALUE_BITS-1:0] v, string text);
    directed_rows.push_back('{v, text});
  endfunction

  // Pick a random value: small numbers, powers of ten and their neighbors,
  // values next to the extremes, and full-width noise so every bit toggles.
  function automatic logic signed [sitda_pkg::VALUE_BITS-1:0] random_value();
    logic signed [sitda_pkg::VALUE_BITS-1:0] v;
    int                                      pick;
    int                                      power;
    pick = $urandom_range(99);
    if (pick < 25) begin
      v = $urandom_range(999);
    end else if (pick < 40) begin
      power = 1;
      repeat ($urandom_range(9)) power = power * 10;
      v = power + $urandom_range(2) - 1;
    end else if (pick < 50) begin
      v = $urandom_range(1) ? (32'h7FFF_FFFF - $urandom_range(3))
                            : (32'h8000_0000 + $urandom_range(3));
    end else begin
      v = $urandom;
    end
    // Flip the sign of the small numbers and powers of ten half of the time.
    if (pick < 40 && $urandom_range(1)) begin
      v = -v;
    end
    return v;
  endfunction

  // Offer one request, hold it until taken, then record what it should
  // produce. At random, idle for a while first, unless in the steady stretch.
  task automatic offer_request(logic signed [sitda_pkg::VALUE_BITS-1:0] v, string text);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 6)) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    if (text.len() == 0) begin
      predict_text(v);
    end else begin
      expect_literal(text);
    end
  endtask

  // Receiver: stall at random, or hold off for a counted stretch on demand.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 30);
      end
    end
  end

  // Check every accepted character against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_char = '{char_code_o, last_o};
      if (pending_text.size() == 0) begin
        note_mismatch("character with no request pending", '{8'd0, 1'b0}, seen_char);
      end else begin
        want_char = pending_text.pop_front();
        if (seen_char.code !== want_char.code || seen_char.fin !== want_char.fin) begin
          note_mismatch("character mismatch", want_char, seen_char);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    in_valid_i = 1'b0;
    value_i    = '0;
    rst_ni     = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: zero, sign extremes, digit-count edges, bit patterns.
    add_row(32'sd0,          "0\n");
    add_row(32'sd1,          "1\n");
    add_row(-32'sd1,         "-1\n");
    add_row(32'sd9,          "9\n");
    add_row(32'sd10,         "10\n");
    add_row(-32'sd10,        "-10\n");
    add_row(32'sd100,        "100\n");
    add_row(32'h7FFF_FFFF,   "2147483647\n");
    add_row(32'h8000_0000,   "-2147483648\n");
    add_row(32'h8000_0001,   "-2147483647\n");
    add_row(32'sd999999999,  "999999999\n");
    add_row(32'sd1000000000, "1000000000\n");
    add_row(-32'sd999999999, "-999999999\n");
    add_row(-32'sd1000000000, "-1000000000\n");
    add_row(32'sd65536,      "65536\n");
    add_row(-32'sd65536,     "-65536\n");
    add_row(32'h5555_5555,   "");
    add_row(32'hAAAA_AAAA,   "");
    add_row(32'sd12345,      "");
    add_row(-32'sd98765,     "");
    add_row(32'h7FFF_0000,   "");
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].value, directed_rows[i].text);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Hold the output off long enough that the input backs up too.
      if (n == 60) begin
        hold_off_left = HOLD_OFF_CYCLES;
      end
      steady = (n >= 150 && n < 210);
      // Drop valid and let the block drain completely once.
      if (n == 260) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_text.size() != 0) @(negedge clk_i);
      end
      offer_request(random_value(), "");
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    // Catch any stray characters after the last newline.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("signed_int_to_decimal_ascii verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #2_000_000;
    $display("signed_int_to_decimal_ascii verification failed");
    $finish;
  end

endmodule
